[rtl/vdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types and fixed widths for the van der Corput sequence generator.
// ----------------------------------------------------------------------------

package vdc_pkg;

	localparam int CNT_W     = 64;                     // index counter width
	localparam int RADIX_W   = 16;                     // base register width
	localparam int SAMPLE_W  = 32;                     // result fraction width
	localparam int DIV_BITS  = 4;                      // quotient bits per divider cycle
	localparam int DIV_STEPS = CNT_W / DIV_BITS;       // divider steps per division
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic MODE_POP    = 1'b0;
	localparam logic MODE_RESEED = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_W0_DIV,
		ST_CHECK,
		ST_K_DIV,
		ST_W_DIV,
		ST_FINISH
	} state_t;

endpackage

[rtl/van_der_corput_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// van_der_corput_generator
// Radical inverse of a 64-bit wrapping index counter in a programmable base.
// ----------------------------------------------------------------------------
// A pop request increments the index counter and returns its radical inverse in
// base radix (values below two act as two) as an unsigned Q0.32 fraction; a
// reseed request loads the counter and returns nothing. All divisions go
// through one shared bit-serial divider that retires four quotient bits per
// cycle. The digit loop of a pop stops once the remaining counter or the
// current weight reaches zero, or after MAX_DIGITS digits (base two gives at
// most 32 digits at the default FRAC_BITS). Each digit costs one division of
// the counter, one of the weight and one check step. in_stall stays high while
// a pop is worked on; a finished sample waits in the output register and the
// next request may be taken meanwhile. radix should only be written while no
// pop is in progress.
// ----------------------------------------------------------------------------

module van_der_corput_generator
	import vdc_pkg::*;
#(
	parameter int FRAC_BITS  = 32,
	parameter int MAX_DIGITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RADIX_W-1:0]  radix,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [CNT_W-1:0]    seed_value,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] sample
);

	localparam int DIG_W = $clog2(MAX_DIGITS + 1);

	state_t state_q, state_nx;

	logic [RADIX_W-1:0]   radix_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIG_W-1:0]     dig_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	logic [RADIX_W-1:0]   b_q;
	logic [CNT_W-1:0]     k_q;
	logic [FRAC_BITS-1:0] w_q;
	logic [RADIX_W-1:0]   digit_q;
	logic [SAMPLE_W-1:0]  prod_q;
	logic [SAMPLE_W-1:0]  acc_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [CNT_W-1:0]     div_n_q;
	logic [RADIX_W-1:0]   div_r_q;

	logic                 in_acc;
	logic                 pop_acc;
	logic                 out_free;
	logic                 div_busy;
	logic                 div_done;
	logic                 loop_done;
	logic [CNT_W-1:0]     cnt_inc;
	logic [RADIX_W-1:0]   b_eff;
	logic [CNT_W-1:0]     w_ext;
	logic [CNT_W-1:0]     div_n_nx;
	logic [RADIX_W-1:0]   div_r_nx;
	logic [47:0]          prod_full;

	assign in_acc   = in_valid && !in_stall;
	assign pop_acc  = in_acc && (mode == MODE_POP);
	assign out_free = !out_valid_q || !out_stall;
	assign div_done = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign b_eff    = (radix_q < RADIX_W'(2)) ? RADIX_W'(2) : radix_q;
	assign w_ext    = CNT_W'(w_q);
	assign loop_done = (k_q == '0) || (w_q == '0) || (dig_q == DIG_W'(MAX_DIGITS));
	assign prod_full = 48'(digit_q) * 48'(w_ext[SAMPLE_W-1:0]);

	// shared divider: DIV_BITS restoring steps per cycle, quotient shifts into div_n
	always_comb begin
		logic [RADIX_W:0]    r_ext;
		logic [RADIX_W-1:0]  r;
		logic [DIV_BITS-1:0] q;
		r = div_r_q;
		q = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			r_ext = {r, div_n_q[CNT_W-1-i]};
			if (r_ext >= {1'b0, b_q}) begin
				r_ext = r_ext - {1'b0, b_q};
				q[DIV_BITS-1-i] = 1'b1;
			end
			r = r_ext[RADIX_W-1:0];
		end
		div_r_nx = r;
		div_n_nx = {div_n_q[CNT_W-DIV_BITS-1:0], q};
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_acc)
					state_nx = ST_W0_DIV;
			end
			ST_W0_DIV: begin
				if (div_done)
					state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				state_nx = loop_done ? ST_FINISH : ST_K_DIV;
			end
			ST_K_DIV: begin
				if (div_done)
					state_nx = ST_W_DIV;
			end
			ST_W_DIV: begin
				if (div_done)
					state_nx = ST_CHECK;
			end
			ST_FINISH: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		div_busy  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			ST_W0_DIV, ST_K_DIV, ST_W_DIV: begin
				div_busy = 1'b1;
			end
			default: begin
				div_busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= RADIX_W'(2);
			cnt_q       <= '0;
			dig_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready)
				radix_q <= radix;
			if (in_acc)
				cnt_q <= (mode == MODE_RESEED) ? seed_value : cnt_inc;
			if (pop_acc)
				dig_q <= '0;
			else if (state_q == ST_W_DIV && div_done)
				dig_q <= dig_q + DIG_W'(1);
			if (div_busy)
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		// the last step of the counter division loads the weight division instead
		if (div_busy && !(state_q == ST_K_DIV && div_done)) begin
			div_n_q <= div_n_nx;
			div_r_q <= div_r_nx;
		end
		case (state_q)
			ST_IDLE: begin
				if (pop_acc) begin
					k_q     <= cnt_inc;
					b_q     <= b_eff;
					acc_q   <= '0;
					div_n_q <= CNT_W'({FRAC_BITS{1'b1}});
					div_r_q <= '0;
				end
			end
			ST_W0_DIV: begin
				// floor(2^F / b) from floor((2^F - 1) / b), bumped when b divides 2^F
				if (div_done)
					w_q <= FRAC_BITS'(div_n_nx + CNT_W'(div_r_nx == b_q - RADIX_W'(1)));
			end
			ST_CHECK: begin
				div_n_q <= k_q;
				div_r_q <= '0;
			end
			ST_K_DIV: begin
				if (div_done) begin
					digit_q <= div_r_nx;
					k_q     <= div_n_nx;
					div_n_q <= w_ext;
					div_r_q <= '0;
				end
			end
			ST_W_DIV: begin
				// only the low sample bits of the product are kept
				prod_q <= prod_full[SAMPLE_W-1:0];
				if (div_done) begin
					w_q   <= FRAC_BITS'(div_n_nx);
					acc_q <= acc_q + prod_q;
				end
			end
			ST_FINISH: begin
				if (out_free)
					sample_q <= acc_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	a_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish state");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K_DIV || state_q == ST_W_DIV) |-> (div_r_q < b_q))
		else $error("divider remainder not below base");

	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		dig_q <= DIG_W'(MAX_DIGITS))
		else $error("digit count beyond limit");

	a_reseed_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode == MODE_RESEED) |=> (state_q == ST_IDLE && cnt_q == $past(seed_value)))
		else $error("reseed started work or missed the counter load");

endmodule
